FILE: sv/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared constants for the masked sample repair core: sample width default,
// result queue depth and the line window codes.
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int RES_DEPTH       = 4;

    localparam logic [1:0] CNT_START    = 2'd0;
    localparam logic [1:0] CNT_FIRST    = 2'd1;
    localparam logic [1:0] CNT_INTERIOR = 2'd2;

endpackage

FILE: sv/masked_sample_repair_core.sv
// ----------------------------------------------------------------------------
// masked_sample_repair_core
// Repairs marked samples on a streamed line from a three-sample window and
// queues the results, one result per sample, two at the end of a longer line.
// ----------------------------------------------------------------------------
// Order: a sample's result is queued at the edge that accepts the next item
// of the line (a one-sample line at its own edge) and is offered from the next
// cycle once the results ahead of it have gone; at a line end the held
// sample's result is queued ahead of the last item's.
// Throughput: one item per cycle while the four-entry result queue holds two
// or fewer (else in_stall); it takes up to two results per cycle, issues one.
// Reset: window state and queue cleared; the next item starts a new line.
// ----------------------------------------------------------------------------
module masked_sample_repair_core #(
    parameter int SAMPLE_BITS = msr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          is_bad,
    input  logic                          line_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic                          was_repaired,
    output logic                          out_last
);
    import msr_pkg::*;

    localparam int PTR_BITS = $clog2(RES_DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    logic [SAMPLE_BITS-1:0] older_sample_reg, older_sample_next;
    logic                   older_bad_reg, older_bad_next;
    logic [SAMPLE_BITS-1:0] held_sample_reg, held_sample_next;
    logic                   held_bad_reg, held_bad_next;
    logic [1:0]             held_count_reg, held_count_next;

    logic [SAMPLE_BITS-1:0] q_sample_reg [RES_DEPTH];
    logic                   q_rep_reg    [RES_DEPTH];
    logic                   q_last_reg   [RES_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]    q_count_reg, q_count_next;

    logic                   in_accept;
    logic                   out_pop;
    logic [1:0]             n_push;
    logic [SAMPLE_BITS:0]   pair_sum;
    logic [SAMPLE_BITS-1:0] avg;
    logic [SAMPLE_BITS-1:0] r0_sample, r1_sample;
    logic                   r0_rep, r0_last, r1_rep;
    logic [PTR_BITS-1:0]    wr_ptr_plus1;

    assign in_stall  = (q_count_reg > CNT_BITS'(RES_DEPTH - 2));
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (q_count_reg != '0);
    assign out_pop   = out_valid && !out_stall;

    assign out_sample   = q_sample_reg[rd_ptr_reg];
    assign was_repaired = q_rep_reg[rd_ptr_reg];
    assign out_last     = q_last_reg[rd_ptr_reg];

    assign pair_sum = {older_sample_reg[SAMPLE_BITS-1], older_sample_reg}
                    + {sample[SAMPLE_BITS-1], sample};
    assign avg      = pair_sum[SAMPLE_BITS:1];

    always_comb
    begin
        r0_sample = held_sample_reg;
        r0_rep    = 1'b0;
        r0_last   = 1'b0;
        case (held_count_reg)
            CNT_START:
            begin
                r0_sample = sample;
                r0_last   = 1'b1;
            end
            CNT_FIRST:
            begin
                if (held_bad_reg && !is_bad)
                begin
                    r0_sample = sample;
                    r0_rep    = 1'b1;
                end
            end
            default:
            begin
                if (held_bad_reg && !older_bad_reg && !is_bad)
                begin
                    r0_sample = avg;
                    r0_rep    = 1'b1;
                end
            end
        endcase

        if (is_bad && !held_bad_reg)
        begin
            r1_sample = held_sample_reg;
            r1_rep    = 1'b1;
        end
        else
        begin
            r1_sample = sample;
            r1_rep    = 1'b0;
        end
    end

    always_comb
    begin
        older_sample_next = older_sample_reg;
        older_bad_next    = older_bad_reg;
        held_sample_next  = held_sample_reg;
        held_bad_next     = held_bad_reg;
        held_count_next   = held_count_reg;
        n_push            = 2'd0;
        if (in_accept)
        begin
            if (held_count_reg == CNT_START)
            begin
                if (line_end)
                begin
                    n_push = 2'd1;
                end
                else
                begin
                    held_sample_next = sample;
                    held_bad_next    = is_bad;
                    held_count_next  = CNT_FIRST;
                end
            end
            else
            begin
                older_sample_next = held_sample_reg;
                older_bad_next    = held_bad_reg;
                held_sample_next  = sample;
                held_bad_next     = is_bad;
                held_count_next   = line_end ? CNT_START : CNT_INTERIOR;
                n_push            = line_end ? 2'd2 : 2'd1;
            end
        end
    end

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_BITS'(1);

    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg + PTR_BITS'(n_push);
        rd_ptr_next  = out_pop ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        q_count_next = q_count_reg + CNT_BITS'(n_push) - CNT_BITS'(out_pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            q_sample_reg[wr_ptr_reg] <= r0_sample;
            q_rep_reg[wr_ptr_reg]    <= r0_rep;
            q_last_reg[wr_ptr_reg]   <= r0_last;
        end
        if (n_push == 2'd2)
        begin
            q_sample_reg[wr_ptr_plus1] <= r1_sample;
            q_rep_reg[wr_ptr_plus1]    <= r1_rep;
            q_last_reg[wr_ptr_plus1]   <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_sample_reg <= '0;
            older_bad_reg    <= 1'b0;
            held_sample_reg  <= '0;
            held_bad_reg     <= 1'b0;
            held_count_reg   <= CNT_START;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            q_count_reg      <= '0;
        end
        else
        begin
            older_sample_reg <= older_sample_next;
            older_bad_reg    <= older_bad_next;
            held_sample_reg  <= held_sample_next;
            held_bad_reg     <= held_bad_next;
            held_count_reg   <= held_count_next;
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            q_count_reg      <= q_count_next;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= CNT_BITS'(RES_DEPTH))
        else $error("result queue overfilled");

    a_window_code: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CNT_INTERIOR)
        else $error("window count reached unused code");

    a_line_end_two: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && line_end && held_count_reg != CNT_START && !out_pop)
        |=> q_count_reg == $past(q_count_reg) + CNT_BITS'(2))
        else $error("line end did not queue two results");

    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && line_end) |=> held_count_reg == CNT_START)
        else $error("window not cleared after line end");

endmodule
